[hdl/gbs_pkg.sv]
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types and constants for the greedy box suppression block.
// ----------------------------------------------------------------------------
package gbs_pkg;

  localparam int MAX_KEPT = 64;
  localparam int IDX_W    = $clog2(MAX_KEPT);
  localparam int CNT_W    = $clog2(MAX_KEPT + 1);
  localparam int COORD_W  = 16;
  localparam int EDGE_W   = COORD_W + 1;
  localparam int AREA_W   = 2 * COORD_W;
  localparam int SLOT_W   = 6;
  localparam int THR_W    = 16;

  localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

  typedef struct packed {
    logic [COORD_W-1:0] box_left;
    logic [COORD_W-1:0] box_top;
    logic [COORD_W-1:0] box_width;
    logic [COORD_W-1:0] box_height;
    logic               frame_end;
  } gbs_in_t;

  typedef struct packed {
    logic              keep;
    logic [SLOT_W-1:0] kept_slot;
    logic              overflow;
    logic              frame_end_out;
  } gbs_out_t;

  // one stored box
  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [EDGE_W-1:0]  right;
    logic [EDGE_W-1:0]  bottom;
    logic [AREA_W-1:0]  area;
  } gbs_entry_t;

endpackage

[hdl/greedy_box_suppression.sv]
// ----------------------------------------------------------------------------
// greedy_box_suppression
// Each accepted box is compared with every box kept so far in this frame,
//   then the result beat is registered; result-side stalls delay it.
// A new box is taken only after the result for the last one is issued; the scan
//   sweeps the kept-box memory one entry per cycle. Reset: sync rst_n empties the store.
// ----------------------------------------------------------------------------
module greedy_box_suppression
  import gbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  gbs_in_t          in_data,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output gbs_out_t         out_data,
  // threshold register
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t state_r;

  // ---- configuration ----
  logic [THR_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // ---- current box ----
  logic [COORD_W-1:0] cur_left_r, cur_top_r, cur_w_r, cur_h_r;
  logic [EDGE_W-1:0]  cur_right_r, cur_bottom_r;
  logic               cur_fend_r;
  logic [AREA_W-1:0]  cur_area_r;

  // ---- kept-box memory, one read port, one write port ----
  gbs_entry_t       kept_mem [MAX_KEPT];
  gbs_entry_t       rd_data_r;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  gbs_entry_t       wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      kept_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= kept_mem[rd_addr];
    end
  end

  // ---- scan control ----
  logic [CNT_W-1:0] count_r;    // boxes stored in this frame
  logic [CNT_W-1:0] rd_idx_r;   // next entry to read
  logic             keep_r;     // still alive after comparisons so far
  logic             rdv_r, s1_v_r, s2_v_r, s3_v_r;
  logic             in_accept;
  logic             pipe_busy;
  logic             out_free;
  logic             store_ok;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign rd_en     = (state_r == ST_SCAN) && (rd_idx_r < count_r);
  assign rd_addr   = rd_idx_r[IDX_W-1:0];
  assign pipe_busy = rdv_r || s1_v_r || s2_v_r || s3_v_r;
  assign out_free  = !out_valid || !out_stall;
  assign store_ok  = (count_r < CNT_W'(MAX_KEPT));

  // store the survivor when the result is issued
  assign wr_en   = (state_r == ST_FINISH) && out_free && keep_r && store_ok;
  assign wr_addr = count_r[IDX_W-1:0];
  always_comb begin
    wr_data.left   = cur_left_r;
    wr_data.top    = cur_top_r;
    wr_data.right  = cur_right_r;
    wr_data.bottom = cur_bottom_r;
    wr_data.area   = cur_area_r;
  end

  // ---- compare pipeline: overlap, intersection, union * threshold, test ----
  logic [EDGE_W-1:0]    lo_x, hi_x, lo_y, hi_y;
  logic [COORD_W-1:0]   iw, ih;
  logic [COORD_W-1:0]   iw_r, ih_r;
  logic [AREA_W-1:0]    karea_r;
  logic [AREA_W-1:0]    inter2_r, inter3_r;
  logic [AREA_W:0]      asum_r;
  logic [AREA_W:0]      uni;
  logic [AREA_W+THR_W:0] prod_r;
  logic                 uni_nz_r;
  logic                 hit;

  always_comb begin
    lo_x = (EDGE_W'(cur_left_r) > EDGE_W'(rd_data_r.left)) ?
           EDGE_W'(cur_left_r) : EDGE_W'(rd_data_r.left);
    hi_x = (cur_right_r < rd_data_r.right) ? cur_right_r : rd_data_r.right;
    lo_y = (EDGE_W'(cur_top_r) > EDGE_W'(rd_data_r.top)) ?
           EDGE_W'(cur_top_r) : EDGE_W'(rd_data_r.top);
    hi_y = (cur_bottom_r < rd_data_r.bottom) ? cur_bottom_r : rd_data_r.bottom;
    // overlap never exceeds the current box's own size, so it fits 16 bits
    iw   = (hi_x > lo_x) ? COORD_W'(hi_x - lo_x) : '0;
    ih   = (hi_y > lo_y) ? COORD_W'(hi_y - lo_y) : '0;
    uni  = asum_r - (AREA_W+1)'(inter2_r);
    // suppress when inter * 2^16 > thr * union, zero union never suppresses
    hit  = s3_v_r && uni_nz_r &&
           ((AREA_W+THR_W+1)'({inter3_r, {THR_W{1'b0}}}) > prod_r);
  end

  always_ff @(posedge clk) begin
    iw_r     <= iw;
    ih_r     <= ih;
    karea_r  <= rd_data_r.area;
    inter2_r <= AREA_W'(iw_r) * AREA_W'(ih_r);
    asum_r   <= (AREA_W+1)'(cur_area_r) + (AREA_W+1)'(karea_r);
    inter3_r <= inter2_r;
    uni_nz_r <= (uni != '0);
    prod_r   <= (AREA_W+THR_W+1)'(thr_r) * (AREA_W+THR_W+1)'(uni);
  end

  // ---- control FSM, result register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      rd_idx_r  <= '0;
      keep_r    <= 1'b0;
      rdv_r     <= 1'b0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rdv_r  <= rd_en;
      s1_v_r <= rdv_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      // result beat taken; FINISH reloads the register itself
      if (out_valid && !out_stall && (state_r != ST_FINISH)) begin
        out_valid <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            cur_left_r   <= in_data.box_left;
            cur_top_r    <= in_data.box_top;
            cur_w_r      <= in_data.box_width;
            cur_h_r      <= in_data.box_height;
            cur_right_r  <= EDGE_W'(in_data.box_left) + EDGE_W'(in_data.box_width);
            cur_bottom_r <= EDGE_W'(in_data.box_top) + EDGE_W'(in_data.box_height);
            cur_fend_r   <= in_data.frame_end;
            rd_idx_r     <= '0;
            keep_r       <= 1'b1;
            state_r      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // area is registered on entering the scan, before the first sum uses it
          cur_area_r <= AREA_W'(cur_w_r) * AREA_W'(cur_h_r);
          if (hit) begin
            keep_r <= 1'b0;
          end
          if (rd_en) begin
            rd_idx_r <= rd_idx_r + 1'b1;
          end else if (!pipe_busy) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid              <= 1'b1;
            out_data.keep          <= keep_r;
            out_data.kept_slot     <= (keep_r && store_ok) ? SLOT_W'(count_r) : '0;
            out_data.overflow      <= keep_r && !store_ok;
            out_data.frame_end_out <= cur_fend_r;
            if (cur_fend_r) begin
              count_r <= '0;
            end else if (keep_r && store_ok) begin
              count_r <= count_r + 1'b1;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
